FILE: hdl/bll_pkg.sv
// Package for the bounded linked list engine: command and status codes and the
// request and response transaction types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bll_pkg;

   // Command codes
   localparam logic [2:0] CMD_ADD_HEAD = 3'd0;
   localparam logic [2:0] CMD_ADD_TAIL = 3'd1;
   localparam logic [2:0] CMD_INSERT   = 3'd2;
   localparam logic [2:0] CMD_REM_HEAD = 3'd3;
   localparam logic [2:0] CMD_REM_TAIL = 3'd4;
   localparam logic [2:0] CMD_REM_VAL  = 3'd5;
   localparam logic [2:0] CMD_SEARCH   = 3'd6;

   // Status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_EMPTY     = 3'd1;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_BAD_SLOT  = 3'd4;

   // Request transaction
   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [3:0]         slot;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [2:0] status;
      logic       found;
      logic [3:0] found_slot;
      logic       is_empty;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/bounded_linked_list_engine.sv
// Top level of the bounded linked list engine: command sequencer, list head/tail
// registers and slot used bits. Depends on bll_pkg and bll_store.
//
//   Channel   Ports                      Direction  Transaction
//   request   start, busy, req_data      in         accepted when start && !busy
//   response  rsp_strobe, rsp_data       out        valid for one cycle, no stall
//
// Add head, add tail to an empty list, remove tail of one or two entries, errors and unused
// codes finish in the execute state. Add tail to a nonempty list then links the old tail to
// the new entry; remove head reads the head's link; insert reads the successor, then links;
// remove tail walks to the entry before it; remove value and search scan from the head.
// The strobe follows the last busy cycle; a new command can be accepted in that same cycle.
// Reset clears the used bits, head, tail and count at once. The response side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module bounded_linked_list_engine #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bll_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output bll_pkg::rsp_type      rsp_data
);

   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_LINK    = 3'd2;
   localparam logic [2:0] S_INS_RD  = 3'd3;
   localparam logic [2:0] S_HEAD_RD = 3'd4;
   localparam logic [2:0] S_WALK    = 3'd5;
   localparam logic [2:0] S_SCAN    = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CAPACITY-1:0]   used_ff, used_in;
   logic [IDX_BITS-1:0]   first_ff, first_in;
   logic [IDX_BITS-1:0]   last_ff, last_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   bll_pkg::rsp_type      rsp_ff, rsp_in;

   // Latched command and walk registers
   logic [2:0]            cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [3:0]            hdl_ff, hdl_in;
   logic [IDX_BITS-1:0]   new_ff, new_in;
   logic [IDX_BITS-1:0]   lnk_tgt_ff, lnk_tgt_in;
   logic [IDX_BITS-1:0]   cur_ff, cur_in;
   logic [IDX_BITS-1:0]   prev_ff, prev_in;
   logic [IDX_BITS-1:0]   pos_ff, pos_in;
   logic [CNT_BITS-1:0]   step_ff, step_in;

   // Memory ports
   logic [IDX_BITS-1:0]   rd_addr;
   logic [VALUE_BITS-1:0] val_rd;
   logic [IDX_BITS-1:0]   lnk_rd;
   logic                  val_we;
   logic [IDX_BITS-1:0]   val_addr;
   logic [VALUE_BITS-1:0] val_wdata;
   logic                  lnk_we;
   logic [IDX_BITS-1:0]   lnk_addr;
   logic [IDX_BITS-1:0]   lnk_wdata;

   // Slot take / release
   logic                  take_en;
   logic [IDX_BITS-1:0]   take_idx;
   logic                  rel_en;
   logic [IDX_BITS-1:0]   rel_idx;

   logic [IDX_BITS-1:0]   free_idx;
   logic                  full;
   logic [IDX_BITS-1:0]   hdl_idx;
   logic                  hdl_ok;

   bll_store #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .val_rd    (val_rd),
      .lnk_rd    (lnk_rd),
      .val_we    (val_we),
      .val_addr  (val_addr),
      .val_wdata (val_wdata),
      .lnk_we    (lnk_we),
      .lnk_addr  (lnk_addr),
      .lnk_wdata (lnk_wdata)
   );

   // Lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   assign full    = (count_ff == CNT_BITS'(CAPACITY));
   assign hdl_idx = IDX_BITS'(hdl_ff);
   assign hdl_ok  = (32'(hdl_ff) < 32'(CAPACITY)) && used_ff[hdl_idx];

   // Command sequencer
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      hdl_in        = hdl_ff;
      new_in        = new_ff;
      lnk_tgt_in    = lnk_tgt_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      rd_addr       = '0;
      val_we        = 1'b0;
      val_addr      = '0;
      val_wdata     = val_ff;
      lnk_we        = 1'b0;
      lnk_addr      = '0;
      lnk_wdata     = '0;
      take_en       = 1'b0;
      take_idx      = free_idx;
      rel_en        = 1'b0;
      rel_idx       = '0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rsp_in.status     = bll_pkg::STAT_OK;
      rsp_in.found      = 1'b0;
      rsp_in.found_slot = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.command;
               val_in   = VALUE_BITS'($signed(req_data.value));
               hdl_in   = req_data.slot;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (cmd_ff) inside
               bll_pkg::CMD_ADD_HEAD: begin
                  if (full) begin
                     rsp_in.status = bll_pkg::STAT_FULL;
                  end else begin
                     val_we    = 1'b1;
                     val_addr  = free_idx;
                     lnk_we    = 1'b1;
                     lnk_addr  = free_idx;
                     lnk_wdata = (count_ff == '0) ? '0 : first_ff;
                     take_en   = 1'b1;
                     if (count_ff == '0) begin
                        last_in = free_idx;
                     end
                     first_in          = free_idx;
                     rsp_in.found_slot = 4'(free_idx);
                  end
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end

               bll_pkg::CMD_ADD_TAIL: begin
                  if (full) begin
                     rsp_in.status = bll_pkg::STAT_FULL;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     val_we    = 1'b1;
                     val_addr  = free_idx;
                     lnk_we    = 1'b1;
                     lnk_addr  = free_idx;
                     lnk_wdata = '0;
                     take_en   = 1'b1;
                     if (count_ff == '0) begin
                        first_in          = free_idx;
                        last_in           = free_idx;
                        rsp_in.found_slot = 4'(free_idx);
                        rsp_strobe_in     = 1'b1;
                        state_in          = S_IDLE;
                     end else begin
                        new_in     = free_idx;
                        lnk_tgt_in = last_ff;
                        state_in   = S_LINK;
                     end
                  end
               end

               bll_pkg::CMD_INSERT: begin
                  if (!hdl_ok) begin
                     rsp_in.status = bll_pkg::STAT_BAD_SLOT;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else if (full) begin
                     rsp_in.status = bll_pkg::STAT_FULL;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     rd_addr    = hdl_idx;
                     new_in     = free_idx;
                     lnk_tgt_in = hdl_idx;
                     state_in   = S_INS_RD;
                  end
               end

               bll_pkg::CMD_REM_HEAD: begin
                  if (count_ff == '0) begin
                     rsp_in.status = bll_pkg::STAT_EMPTY;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     rd_addr  = first_ff;
                     state_in = S_HEAD_RD;
                  end
               end

               bll_pkg::CMD_REM_TAIL: begin
                  if (count_ff == '0) begin
                     rsp_in.status = bll_pkg::STAT_EMPTY;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else if (count_ff == CNT_BITS'(1)) begin
                     rel_en        = 1'b1;
                     rel_idx       = last_ff;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else if (count_ff == CNT_BITS'(2)) begin
                     // new tail is the head, no walk needed
                     lnk_we        = 1'b1;
                     lnk_addr      = first_ff;
                     lnk_wdata     = '0;
                     last_in       = first_ff;
                     rel_en        = 1'b1;
                     rel_idx       = last_ff;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     rd_addr  = first_ff;
                     step_in  = count_ff - CNT_BITS'(3);
                     state_in = S_WALK;
                  end
               end

               bll_pkg::CMD_REM_VAL, bll_pkg::CMD_SEARCH: begin
                  if (count_ff == '0) begin
                     rsp_in.status = bll_pkg::STAT_EMPTY;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     rd_addr  = first_ff;
                     cur_in   = first_ff;
                     prev_in  = first_ff;
                     pos_in   = '0;
                     state_in = S_SCAN;
                  end
               end

               default: begin
                  // unused command code: no change
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end

         // Insert: successor of the handle is back, place the new entry
         S_INS_RD: begin
            val_we    = 1'b1;
            val_addr  = new_ff;
            lnk_we    = 1'b1;
            lnk_addr  = new_ff;
            lnk_wdata = lnk_rd;
            take_en   = 1'b1;
            take_idx  = new_ff;
            state_in  = S_LINK;
         end

         // Hook the new entry behind its predecessor
         S_LINK: begin
            lnk_we    = 1'b1;
            lnk_addr  = lnk_tgt_ff;
            lnk_wdata = new_ff;
            if (lnk_tgt_ff == last_ff) begin
               last_in = new_ff;
            end
            rsp_in.found_slot = 4'(new_ff);
            rsp_strobe_in     = 1'b1;
            state_in          = S_IDLE;
         end

         S_HEAD_RD: begin
            first_in      = lnk_rd;
            rel_en        = 1'b1;
            rel_idx       = first_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         // Walk to the entry before the tail, one link read a cycle
         S_WALK: begin
            if (step_ff == '0) begin
               lnk_we        = 1'b1;
               lnk_addr      = lnk_rd;
               lnk_wdata     = '0;
               last_in       = lnk_rd;
               rel_en        = 1'b1;
               rel_idx       = last_ff;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_addr = lnk_rd;
               step_in = step_ff - 1'b1;
            end
         end

         // Compare one entry a cycle; value and link of cur_ff are on the read port
         S_SCAN: begin
            if (val_rd == val_ff) begin
               if (cmd_ff == bll_pkg::CMD_SEARCH) begin
                  rsp_in.found      = 1'b1;
                  rsp_in.found_slot = 4'(cur_ff);
               end else begin
                  if (pos_ff == '0) begin
                     first_in = lnk_rd;
                  end else begin
                     lnk_we    = 1'b1;
                     lnk_addr  = prev_ff;
                     lnk_wdata = (cur_ff == last_ff) ? '0 : lnk_rd;
                     if (cur_ff == last_ff) begin
                        last_in = prev_ff;
                     end
                  end
                  rel_en  = 1'b1;
                  rel_idx = cur_ff;
               end
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (CNT_BITS'(pos_ff) + 1'b1 == count_ff) begin
               rsp_in.status = bll_pkg::STAT_NOT_FOUND;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               prev_in = cur_ff;
               cur_in  = lnk_rd;
               pos_in  = pos_ff + 1'b1;
               rd_addr = lnk_rd;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Slot bookkeeping
      if (take_en) begin
         used_in[take_idx] = 1'b1;
         count_in          = count_ff + 1'b1;
      end
      if (rel_en) begin
         used_in[rel_idx] = 1'b0;
         count_in         = count_ff - 1'b1;
         if (count_in == '0) begin
            first_in = '0;
            last_in  = '0;
         end
      end

      rsp_in.is_empty = (count_in == '0);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         first_ff      <= '0;
         last_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      cmd_ff     <= cmd_in;
      val_ff     <= val_in;
      hdl_ff     <= hdl_in;
      new_ff     <= new_in;
      lnk_tgt_ff <= lnk_tgt_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      pos_ff     <= pos_in;
      step_ff    <= step_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   a_used_count : assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(count_ff))
      else $error("used bits disagree with entry count");

   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

FILE: hdl/bll_store.sv
// Slot storage of the linked list engine: value memory and link memory, one write
// and one registered read port each, read at a shared address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bll_store #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   localparam int IDX_BITS  = $clog2(CAPACITY)
) (
   input  wire logic                  clock,
   input  wire logic [IDX_BITS-1:0]   rd_addr,
   output logic      [VALUE_BITS-1:0] val_rd,
   output logic      [IDX_BITS-1:0]   lnk_rd,
   input  wire logic                  val_we,
   input  wire logic [IDX_BITS-1:0]   val_addr,
   input  wire logic [VALUE_BITS-1:0] val_wdata,
   input  wire logic                  lnk_we,
   input  wire logic [IDX_BITS-1:0]   lnk_addr,
   input  wire logic [IDX_BITS-1:0]   lnk_wdata
);

   logic [VALUE_BITS-1:0] value_mem [CAPACITY];
   logic [IDX_BITS-1:0]   link_mem  [CAPACITY];
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [IDX_BITS-1:0]   lnk_rd_ff;

   // Value memory
   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_addr] <= val_wdata;
      end
      val_rd_ff <= value_mem[rd_addr];
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (lnk_we) begin
         link_mem[lnk_addr] <= lnk_wdata;
      end
      lnk_rd_ff <= link_mem[rd_addr];
   end

   assign val_rd = val_rd_ff;
   assign lnk_rd = lnk_rd_ff;

endmodule

`default_nettype wire
